// ----- src/pidcr_pkg.sv -----
// Shared types and constants for the PID controller with integrator reset.
package pidcr_pkg;

  localparam int TICK_SHIFT = 10;   // tick rate of 1024 per second
  localparam int MUL_STEPS  = 16;   // multiplier bits consumed, one per cycle
  localparam int DIV_STEPS  = 32;   // quotient bits produced, one per cycle

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_P   = 3'd0;
  localparam cfg_idx_t REG_GAIN_I   = 3'd1;
  localparam cfg_idx_t REG_GAIN_D   = 3'd2;
  localparam cfg_idx_t REG_SETPOINT = 3'd3;
  localparam cfg_idx_t REG_LIMIT    = 3'd4;
  localparam cfg_idx_t REG_STOP     = 3'd5;
  localparam cfg_idx_t REG_MAP      = 3'd6;

  typedef struct packed {
    logic        start;
    logic [47:0] a;
    logic [15:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/pidcr_ifs.sv -----
// Handshake channel interfaces for samples, results and register writes.
interface pidcr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measurement;
  logic        [15:0] elapsed_ticks;
  modport source (output valid, measurement, elapsed_ticks, input ready);
  modport sink   (input valid, measurement, elapsed_ticks, output ready);
endinterface

interface pidcr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic signed [15:0] rotation;
  logic               stopped;
  modport source (output valid, drive, rotation, stopped, input ready);
  modport sink   (input valid, drive, rotation, stopped, output ready);
endinterface

interface pidcr_cfg_if;
  logic                valid;
  logic                ready;
  pidcr_pkg::cfg_idx_t index;
  logic [15:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/pidcr_mul.sv -----
// Unsigned shift-add multiplier that consumes one multiplier bit per cycle.
module pidcr_mul (
  input  logic                clk,
  input  logic                rst,
  input  pidcr_pkg::mul_req_t req,
  output pidcr_pkg::mul_rsp_t rsp
);
  import pidcr_pkg::*;

  logic [63:0] mcand;
  logic [15:0] mplier;
  logic [63:0] acc;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        mcand  <= {16'd0, req.a};
        mplier <= req.b;
        acc    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[15:1]};
        cnt    <= cnt + 4'd1;
        if (cnt == 4'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ----- src/pidcr_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module pidcr_div (
  input  logic                clk,
  input  logic                rst,
  input  pidcr_pkg::div_req_t req,
  output pidcr_pkg::div_rsp_t rsp
);
  import pidcr_pkg::*;

  logic [15:0] divisor;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;

  assign trial = {rem, quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        divisor <= req.divisor;
        rem     <= '0;
        quo     <= req.dividend;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 16'(trial - {1'b0, divisor});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- src/pid_with_crossing_reset.sv -----
// PID controller: a sample enters, and after the steps below one result beat is valid.
// Each sample runs five serial multiplies and two serial divides on one shared multiplier
// and one divider, plus one state to form the drive and one to load the output register,
// so a new sample is taken only once the previous one is handed over. The next sample is
// accepted while the previous result still waits; a new beat is only loaded once it has left.
// Synchronous reset clears the gains, setpoint and stop band, sets the limit to 32767 and the
// rotation scale to 9175, clears the integral and arms the first-sample flag.
module pid_with_crossing_reset (
  input  logic   clk,
  input  logic   rst,
  pidcr_cfg_if.sink   cfg,
  pidcr_in_if.sink    sample,
  pidcr_out_if.source result
);
  import pidcr_pkg::*;

  // Sequencer states. Each waiting state holds until the serial unit reports done.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MI   = 4'd1;  // error times ticks
  localparam logic [3:0] ST_DV   = 4'd2;  // error change over ticks
  localparam logic [3:0] ST_MP   = 4'd3;  // proportional term
  localparam logic [3:0] ST_MII  = 4'd4;  // integral term
  localparam logic [3:0] ST_MD   = 4'd5;  // derivative term
  localparam logic [3:0] ST_DRV  = 4'd6;  // scale, clamp and stop band
  localparam logic [3:0] ST_MR   = 4'd7;  // drive times rotation scale
  localparam logic [3:0] ST_DR   = 4'd8;  // divide by twice the limit
  localparam logic [3:0] ST_OUT  = 4'd9;  // hand over to the output register

  // Configuration registers.
  logic signed [15:0] gain_p, gain_i, gain_d, setpoint;
  logic        [14:0] output_limit, stop_band;
  logic        [15:0] rot_scale;

  // Loop state that persists from sample to sample.
  logic signed [47:0] integral_sum;
  logic signed [16:0] previous_error;
  logic               first_sample;

  // Per-sample working registers.
  logic [3:0]         state;
  logic signed [16:0] err;
  logic [15:0]        ticks;
  logic               diff_neg;
  logic signed [28:0] deriv;
  logic signed [55:0] acc;
  logic signed [15:0] drive;
  logic signed [15:0] rotation;
  logic               stopped;
  logic               rot_zero;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pidcr_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  pidcr_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Register writes are taken only while no sample is being worked on.
  assign cfg.ready    = (state == ST_IDLE);
  assign sample.ready = (state == ST_IDLE);

  // The output register takes a new beat once the previous one has left.
  logic out_load;
  assign out_load = (state == ST_OUT) && (!result.valid || result.ready);

  // Error of the incoming sample and its magnitude.
  logic signed [16:0] err_in;
  logic        [16:0] err_in_abs;
  logic        [16:0] err_abs;
  assign err_in     = 17'(setpoint) - 17'(sample.measurement);
  assign err_in_abs = err_in[16] ? 17'(-err_in) : 17'(err_in);
  assign err_abs    = err[16] ? 17'(-err) : 17'(err);

  // Integral accumulation with saturation to 48 bits.
  logic signed [33:0] inc;
  logic signed [48:0] int_sum;
  logic signed [47:0] int_sat;
  logic signed [47:0] int_acc;
  logic               sign_change;
  logic signed [47:0] int_new;
  assign inc = err[16] ? -$signed({1'b0, mul_rsp.product[32:0]})
                       :  $signed({1'b0, mul_rsp.product[32:0]});
  assign int_sum = 49'(integral_sum) + 49'(inc);
  always_comb begin
    if (int_sum[48] != int_sum[47]) begin
      int_sat = int_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      int_sat = int_sum[47:0];
    end
  end
  assign int_acc     = first_sample ? integral_sum : int_sat;
  assign sign_change = (err[16] != previous_error[16]) ||
                       ((err == 17'sd0) != (previous_error == 17'sd0));
  assign int_new     = sign_change ? 48'sd0 : int_acc;

  // Error change, scaled by the tick rate, as the divider's dividend.
  logic signed [17:0] diff;
  logic        [17:0] diff_abs;
  assign diff     = 18'(err) - 18'(previous_error);
  assign diff_abs = diff[17] ? 18'(-diff) : 18'(diff);

  // Magnitudes of the signed multiplier operands.
  logic [15:0] gp_abs, gi_abs, gd_abs;
  logic [47:0] int_abs;
  logic [27:0] deriv_abs;
  assign gp_abs    = gain_p[15] ? 16'(-gain_p) : 16'(gain_p);
  assign gi_abs    = gain_i[15] ? 16'(-gain_i) : 16'(gain_i);
  assign gd_abs    = gain_d[15] ? 16'(-gain_d) : 16'(gain_d);
  assign int_abs   = integral_sum[47] ? 48'(-integral_sum) : 48'(integral_sum);
  assign deriv_abs = deriv[28] ? 28'(-deriv) : 28'(deriv);

  // Signed products of the three terms, widened to the accumulator.
  logic signed [55:0] term_p, term_i, term_d;
  logic [55:0]        mag_p, mag_i, mag_d;
  assign mag_p  = 56'(mul_rsp.product[32:0]);
  assign mag_i  = 56'(mul_rsp.product[63:TICK_SHIFT]);
  assign mag_d  = 56'(mul_rsp.product[43:0]);
  assign term_p = (err[16] ^ gain_p[15]) ? -$signed(mag_p) : $signed(mag_p);
  assign term_i = (integral_sum[47] ^ gain_i[15]) ? -$signed(mag_i) : $signed(mag_i);
  assign term_d = (deriv[28] ^ gain_d[15]) ? -$signed(mag_d) : $signed(mag_d);

  // Drive: divide by 256 toward zero, clamp, then apply the stop band.
  logic [55:0] acc_abs;
  logic [47:0] acc_mag;
  logic [14:0] drv_mag;
  logic        in_band;
  logic [14:0] drv_fin;
  assign acc_abs = acc[55] ? 56'(-acc) : 56'(acc);
  assign acc_mag = acc_abs[55:8];
  assign drv_mag = (acc_mag > 48'(output_limit)) ? output_limit : acc_mag[14:0];
  assign in_band = err_abs < 17'(stop_band);
  assign drv_fin = in_band ? 15'd0 : drv_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      setpoint       <= '0;
      output_limit   <= 15'd32767;
      stop_band      <= '0;
      rot_scale      <= 16'd9175;
      integral_sum   <= '0;
      previous_error <= '0;
      first_sample   <= 1'b1;
      state          <= ST_IDLE;
      mul_req.start  <= 1'b0;
      div_req.start  <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_GAIN_P: gain_p <= $signed(cfg.data);
          REG_GAIN_I: gain_i <= $signed(cfg.data);
          REG_GAIN_D: gain_d <= $signed(cfg.data);
          REG_SETPOINT: begin
            setpoint       <= $signed(cfg.data);
            integral_sum   <= '0;
            previous_error <= '0;
            first_sample   <= 1'b1;
          end
          REG_LIMIT:  output_limit   <= cfg.data[14:0];
          REG_STOP:   stop_band      <= cfg.data[14:0];
          REG_MAP:    rot_scale      <= cfg.data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            err           <= err_in;
            ticks         <= sample.elapsed_ticks;
            mul_req.start <= 1'b1;
            mul_req.a     <= 48'(err_in_abs);
            mul_req.b     <= sample.elapsed_ticks;
            state         <= ST_MI;
          end
        end
        ST_MI: begin
          if (mul_rsp.done) begin
            integral_sum     <= int_new;
            diff_neg         <= diff[17];
            div_req.start    <= 1'b1;
            div_req.dividend <= {4'd0, diff_abs, 10'd0};
            div_req.divisor  <= ticks;
            state            <= ST_DV;
          end
        end
        ST_DV: begin
          if (div_rsp.done) begin
            if (first_sample || ticks == 16'd0) begin
              deriv <= '0;
            end else if (diff_neg) begin
              deriv <= -$signed({1'b0, div_rsp.quotient[27:0]});
            end else begin
              deriv <= $signed({1'b0, div_rsp.quotient[27:0]});
            end
            mul_req.start <= 1'b1;
            mul_req.a     <= 48'(err_abs);
            mul_req.b     <= gp_abs;
            state         <= ST_MP;
          end
        end
        ST_MP: begin
          if (mul_rsp.done) begin
            acc           <= term_p;
            mul_req.start <= 1'b1;
            mul_req.a     <= int_abs;
            mul_req.b     <= gi_abs;
            state         <= ST_MII;
          end
        end
        ST_MII: begin
          if (mul_rsp.done) begin
            acc           <= acc + term_i;
            mul_req.start <= 1'b1;
            mul_req.a     <= 48'(deriv_abs);
            mul_req.b     <= gd_abs;
            state         <= ST_MD;
          end
        end
        ST_MD: begin
          if (mul_rsp.done) begin
            acc   <= acc - term_d;
            state <= ST_DRV;
          end
        end
        ST_DRV: begin
          drive          <= acc[55] ? -$signed({1'b0, drv_fin}) : $signed({1'b0, drv_fin});
          stopped        <= in_band;
          rot_zero       <= (drv_fin < stop_band) || (output_limit == 15'd0);
          if (in_band) begin
            integral_sum <= '0;
          end
          previous_error <= err;
          first_sample   <= 1'b0;
          mul_req.start  <= 1'b1;
          mul_req.a      <= 48'(drv_fin);
          mul_req.b      <= rot_scale;
          state          <= ST_MR;
        end
        ST_MR: begin
          if (mul_rsp.done) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= mul_rsp.product[31:0];
            div_req.divisor  <= {output_limit, 1'b0};
            state            <= ST_DR;
          end
        end
        ST_DR: begin
          if (div_rsp.done) begin
            if (rot_zero) begin
              rotation <= '0;
            end else if (drive[15]) begin
              rotation <= $signed(div_rsp.quotient[15:0]);
            end else begin
              rotation <= -$signed(div_rsp.quotient[15:0]);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // The finished beat waits here until the previous one has left.
          if (out_load) begin
            result.drive    <= drive;
            result.rotation <= rotation;
            result.stopped  <= stopped;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
